/* src/lfc_pkg.sv */
package lfc_pkg;

  localparam int LFC_BYTES_W     = 40;
  localparam int LFC_IDENT_W     = 31;
  localparam int LFC_MODE_W      = 2;
  localparam int LFC_THR_W       = 40;
  localparam int LFC_CFG_DATA_W  = 40;
  localparam int LFC_CFG_INDEX_W = 1;
  localparam int LFC_PCT_W       = 14;
  localparam int LFC_MAX_FLOWS   = 64;

  localparam logic [LFC_PCT_W-1:0] LFC_PCT_FULL = 14'd10000;

  localparam logic [LFC_MODE_W-1:0] MODE_BYTE_SHARE = 2'd0;
  localparam logic [LFC_MODE_W-1:0] MODE_COUNT      = 2'd1;
  localparam logic [LFC_MODE_W-1:0] MODE_VALUE      = 2'd2;
  localparam logic [LFC_MODE_W-1:0] MODE_UNUSED     = 2'd3;

  localparam logic [LFC_CFG_INDEX_W-1:0] REG_CLASS_MODE      = 1'b0;
  localparam logic [LFC_CFG_INDEX_W-1:0] REG_CLASS_THRESHOLD = 1'b1;

  typedef struct packed {
    logic [LFC_BYTES_W-1:0] flow_bytes;
    logic [LFC_IDENT_W-1:0] flow_ident;
    logic                   last_flow;
  } lfc_in_t;

  typedef struct packed {
    logic [LFC_IDENT_W-1:0] result_ident;
    logic                   is_large;
    logic                   threshold_error;
    logic                   overflow_flag;
    logic                   last_result;
  } lfc_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_PREP2,
    ST_RD_I,
    ST_GET_I,
    ST_SCAN,
    ST_MULT,
    ST_CMP,
    ST_EMIT
  } lfc_state_t;

endpackage

/* src/large_flow_classifier_unit.sv */
// Flows of one job are loaded one per cycle while busy is low; start with busy low is a
// transfer. The flow marked last ends the job: busy rises and one result per stored flow
// follows in load order, each shown for a single cycle on out_valid, and the receiver
// cannot hold them off. Flows beyond MAX_FLOWS are dropped and flagged. In value mode, in the
// unused mode, or when a percent threshold is out of range, each result is read from the flow
// memory and emitted with no scan. In the percent modes every flow is ranked by a scan over
// the flow memory through its single read port and then scaled by one shared multiplier.
// Configuration must be written only while no job is in progress; the block itself does
// not enforce this.
module large_flow_classifier_unit #(
  parameter int MAX_FLOWS = lfc_pkg::LFC_MAX_FLOWS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  lfc_pkg::lfc_in_t                    in_data,
  output logic                                out_valid,
  output lfc_pkg::lfc_out_t                   out_data,
  input  logic                                cfg_we,
  input  logic [lfc_pkg::LFC_CFG_INDEX_W-1:0] cfg_index,
  input  logic [lfc_pkg::LFC_CFG_DATA_W-1:0]  cfg_wdata
);
  import lfc_pkg::*;

  localparam int IDX_W  = $clog2(MAX_FLOWS);
  localparam int CNT_W  = $clog2(MAX_FLOWS + 1);
  localparam int TOT_W  = LFC_BYTES_W + CNT_W;
  localparam int PROD_W = TOT_W + LFC_PCT_W;
  localparam int WORD_W = LFC_BYTES_W + LFC_IDENT_W;

  lfc_state_t state_r, state_nxt;

  logic [LFC_MODE_W-1:0]  mode_r;
  logic [LFC_THR_W-1:0]   thr_r;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [TOT_W-1:0]       total_r, total_nxt;
  logic                   dropped_r, dropped_nxt;

  logic [WORD_W-1:0]      mem [MAX_FLOWS];
  logic [WORD_W-1:0]      rd_q_r;
  logic [IDX_W-1:0]       rd_addr;
  logic                   mem_we;

  logic [IDX_W-1:0]       i_r, i_nxt;
  logic [CNT_W-1:0]       j_r, j_nxt;
  logic [IDX_W-1:0]       pj_r, pj_nxt;
  logic                   pv_r, pv_nxt;
  logic [CNT_W-1:0]       rank_r, rank_nxt;
  logic [TOT_W-1:0]       acc_r, acc_nxt;
  logic [LFC_BYTES_W-1:0] size_i_r, size_i_nxt;
  logic [LFC_IDENT_W-1:0] id_i_r, id_i_nxt;
  logic                   large_r, large_nxt;
  logic [PROD_W-1:0]      jprod_r, jprod_nxt;
  logic [PROD_W-1:0]      mul_q_r;
  logic [TOT_W-1:0]       mul_a;
  logic [LFC_PCT_W-1:0]   mul_b;

  logic                   in_accept;
  logic                   value_mode;
  logic                   thr_err;
  logic                   scan_mode;
  logic                   last_i;
  logic                   ranks_first;
  logic [LFC_BYTES_W-1:0] rd_bytes;
  logic [LFC_IDENT_W-1:0] rd_ident;

  assign in_accept  = start && !busy;
  assign value_mode = (mode_r == MODE_VALUE) || (mode_r == MODE_UNUSED);
  assign thr_err    = !value_mode && (thr_r > LFC_THR_W'(LFC_PCT_FULL));
  assign scan_mode  = !value_mode && !thr_err;
  assign last_i     = (CNT_W'(i_r) + CNT_W'(1)) == cnt_r;
  assign rd_bytes   = rd_q_r[WORD_W-1:LFC_IDENT_W];
  assign rd_ident   = rd_q_r[LFC_IDENT_W-1:0];
  assign mem_we     = in_accept && (cnt_r < CNT_W'(MAX_FLOWS));

  always_comb begin
    if (rd_bytes != size_i_r) begin
      ranks_first = (mode_r == MODE_BYTE_SHARE) ? (rd_bytes > size_i_r) : (rd_bytes < size_i_r);
    end else if (rd_ident != id_i_r) begin
      ranks_first = rd_ident < id_i_r;
    end else begin
      ranks_first = pj_r < i_r;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept && in_data.last_flow) state_nxt = ST_PREP;
      end
      ST_PREP:  state_nxt = ST_PREP2;
      ST_PREP2: state_nxt = ST_RD_I;
      ST_RD_I:  state_nxt = ST_GET_I;
      ST_GET_I: state_nxt = scan_mode ? ST_SCAN : ST_EMIT;
      ST_SCAN: begin
        if ((j_r == cnt_r) && !pv_r) state_nxt = ST_MULT;
      end
      ST_MULT:  state_nxt = ST_CMP;
      ST_CMP:   state_nxt = ST_EMIT;
      ST_EMIT:  state_nxt = last_i ? ST_IDLE : ST_RD_I;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt     = cnt_r;
    total_nxt   = total_r;
    dropped_nxt = dropped_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    pj_nxt      = pj_r;
    pv_nxt      = pv_r;
    rank_nxt    = rank_r;
    acc_nxt     = acc_r;
    size_i_nxt  = size_i_r;
    id_i_nxt    = id_i_r;
    large_nxt   = large_r;
    jprod_nxt   = jprod_r;
    rd_addr     = i_r;
    mul_a       = '0;
    mul_b       = '0;
    busy        = (state_r != ST_IDLE);
    out_valid   = (state_r == ST_EMIT);
    out_data.result_ident    = id_i_r;
    out_data.is_large        = large_r;
    out_data.threshold_error = thr_err;
    out_data.overflow_flag   = dropped_r;
    out_data.last_result     = last_i;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (mem_we) begin
            cnt_nxt   = cnt_r + CNT_W'(1);
            total_nxt = total_r + TOT_W'(in_data.flow_bytes);
          end else begin
            dropped_nxt = 1'b1;
          end
        end
      end
      ST_PREP: begin
        if (mode_r == MODE_COUNT) begin
          mul_a = TOT_W'(cnt_r);
          mul_b = thr_r[LFC_PCT_W-1:0];
        end else begin
          mul_a = total_r;
          mul_b = LFC_PCT_FULL - thr_r[LFC_PCT_W-1:0];
        end
      end
      ST_PREP2: begin
        jprod_nxt = mul_q_r;
        i_nxt     = '0;
      end
      ST_RD_I: begin
        rd_addr = i_r;
      end
      ST_GET_I: begin
        size_i_nxt = rd_bytes;
        id_i_nxt   = rd_ident;
        large_nxt  = value_mode && (rd_bytes >= thr_r);
        j_nxt      = '0;
        pv_nxt     = 1'b0;
        rank_nxt   = '0;
        acc_nxt    = '0;
      end
      ST_SCAN: begin
        rd_addr = j_r[IDX_W-1:0];
        if (j_r != cnt_r) begin
          j_nxt  = j_r + CNT_W'(1);
          pj_nxt = j_r[IDX_W-1:0];
          pv_nxt = 1'b1;
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r && ranks_first) begin
          rank_nxt = rank_r + CNT_W'(1);
          acc_nxt  = acc_r + TOT_W'(rd_bytes);
        end
      end
      ST_MULT: begin
        mul_b = LFC_PCT_FULL;
        if (mode_r == MODE_COUNT) begin
          mul_a = TOT_W'(rank_r) + TOT_W'(1);
        end else begin
          mul_a = acc_r;
        end
      end
      ST_CMP: begin
        if (mode_r == MODE_COUNT) begin
          // A nonzero threshold always makes at least the lowest-ranked flow small.
          if ((thr_r != '0) && (jprod_r < PROD_W'(LFC_PCT_FULL))) begin
            large_nxt = (rank_r != '0);
          end else begin
            large_nxt = mul_q_r > jprod_r;
          end
        end else begin
          large_nxt = mul_q_r < jprod_r;
        end
      end
      ST_EMIT: begin
        if (last_i) begin
          cnt_nxt     = '0;
          total_nxt   = '0;
          dropped_nxt = 1'b0;
        end else begin
          i_nxt = i_r + IDX_W'(1);
        end
      end
      default: begin
        rd_addr = i_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      total_r   <= '0;
      dropped_r <= 1'b0;
      mode_r    <= MODE_BYTE_SHARE;
      thr_r     <= '0;
      pv_r      <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      total_r   <= total_nxt;
      dropped_r <= dropped_nxt;
      pv_r      <= pv_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_CLASS_MODE:      mode_r <= cfg_wdata[LFC_MODE_W-1:0];
          REG_CLASS_THRESHOLD: thr_r  <= cfg_wdata[LFC_THR_W-1:0];
          default:             mode_r <= mode_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    j_r      <= j_nxt;
    pj_r     <= pj_nxt;
    rank_r   <= rank_nxt;
    acc_r    <= acc_nxt;
    size_i_r <= size_i_nxt;
    id_i_r   <= id_i_nxt;
    large_r  <= large_nxt;
    jprod_r  <= jprod_nxt;
    mul_q_r  <= PROD_W'(mul_a) * PROD_W'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[IDX_W-1:0]] <= {in_data.flow_bytes, in_data.flow_ident};
    end
    rd_q_r <= mem[rd_addr];
  end

endmodule

/* src/lfc_checker.sv */
module lfc_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                start,
  input logic                                busy,
  input lfc_pkg::lfc_in_t                    in_data,
  input logic                                out_valid,
  input lfc_pkg::lfc_out_t                   out_data,
  input logic                                cfg_we,
  input logic [lfc_pkg::LFC_CFG_INDEX_W-1:0] cfg_index,
  input logic [lfc_pkg::LFC_CFG_DATA_W-1:0]  cfg_wdata
);
  import lfc_pkg::*;

  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result shown while the block is idle");

  a_last_flow_starts_job: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.last_flow) |=> busy)
    else $error("last flow transfer did not start the result phase");

  a_last_result_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.last_result) |=> !busy)
    else $error("block still busy after the final result");

  a_results_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("results in adjacent cycles");

  a_cfg_while_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> (!busy && !$isunknown({cfg_index, cfg_wdata})))
    else $error("configuration written while a job is in progress");

endmodule

bind large_flow_classifier_unit lfc_checker u_lfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data),
  .cfg_we    (cfg_we),
  .cfg_index (cfg_index),
  .cfg_wdata (cfg_wdata)
);

/* tb/large_flow_classifier_unit_tb.sv */
`timescale 1ns / 1ps

module large_flow_classifier_unit_tb;
  import lfc_pkg::*;

  localparam logic [LFC_BYTES_W-1:0] BYTES_MAX = '1;
  localparam logic [LFC_IDENT_W-1:0] IDENT_MAX = '1;
  localparam logic [LFC_THR_W-1:0]   THR_MAX   = '1;

  logic                       clk       = 1'b0;
  logic                       rst_n     = 1'b0;
  logic                       start     = 1'b0;
  logic                       busy;
  lfc_in_t                    in_data   = '0;
  logic                       out_valid;
  lfc_out_t                   out_data;
  logic                       cfg_we    = 1'b0;
  logic [LFC_CFG_INDEX_W-1:0] cfg_index = '0;
  logic [LFC_CFG_DATA_W-1:0]  cfg_wdata = '0;

  lfc_in_t  pend_flows[$];
  lfc_out_t expected_results[$];
  lfc_out_t seen_result;

  logic [LFC_BYTES_W-1:0] flow_size_mem [LFC_MAX_FLOWS];
  logic [LFC_IDENT_W-1:0] flow_ident_mem[LFC_MAX_FLOWS];
  int                     flows_held = 0;
  logic [45:0]            bytes_held = '0;
  bit                     drop_seen  = 1'b0;
  logic [LFC_MODE_W-1:0]  cur_mode   = MODE_BYTE_SHARE;
  logic [LFC_THR_W-1:0]   cur_thr    = '0;

  int mismatches  = 0;
  int item_total  = 0;
  int gap_left    = 0;
  int burst_left  = 0;
  bit steady_feed = 1'b1;

  large_flow_classifier_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  function automatic bit ranks_ahead(input int j, input int i, input bit descending);
    if (flow_size_mem[j] != flow_size_mem[i]) begin
      return descending ? (flow_size_mem[j] > flow_size_mem[i])
                        : (flow_size_mem[j] < flow_size_mem[i]);
    end
    if (flow_ident_mem[j] != flow_ident_mem[i]) begin
      return flow_ident_mem[j] < flow_ident_mem[i];
    end
    return j < i;
  endfunction

  // Stores a flow unless full; on a job's last flow, queues each stored flow's result.
  function automatic void load_flow(input lfc_in_t f);
    lfc_out_t  r;
    int        i;
    int        j;
    int        small_cnt;
    int        rank;
    bit [63:0] ahead_bytes;
    if (flows_held < LFC_MAX_FLOWS) begin
      flow_size_mem[flows_held]  = f.flow_bytes;
      flow_ident_mem[flows_held] = f.flow_ident;
      flows_held++;
      bytes_held += 46'(f.flow_bytes);
    end else begin
      drop_seen = 1'b1;
    end
    if (!f.last_flow) return;
    for (i = 0; i < flows_held; i++) begin
      r = '0;
      r.result_ident  = flow_ident_mem[i];
      r.overflow_flag = drop_seen;
      r.last_result   = (i == flows_held - 1);
      if (cur_mode == MODE_VALUE || cur_mode == MODE_UNUSED) begin
        r.is_large = (flow_size_mem[i] >= cur_thr);
      end else if (cur_thr > LFC_THR_W'(LFC_PCT_FULL)) begin
        r.threshold_error = 1'b1;
      end else if (cur_mode == MODE_COUNT) begin
        small_cnt = int'(64'(cur_thr) * 64'(flows_held) / 64'(LFC_PCT_FULL));
        if (cur_thr != 0 && small_cnt == 0) small_cnt = 1;
        if (small_cnt > flows_held) small_cnt = flows_held;
        rank = 0;
        for (j = 0; j < flows_held; j++) begin
          if (ranks_ahead(j, i, 1'b0)) rank++;
        end
        r.is_large = (rank >= small_cnt);
      end else begin
        ahead_bytes = '0;
        for (j = 0; j < flows_held; j++) begin
          if (ranks_ahead(j, i, 1'b1)) ahead_bytes += 64'(flow_size_mem[j]);
        end
        r.is_large = (ahead_bytes * 64'(LFC_PCT_FULL)) <
                     (64'(bytes_held) * (64'(LFC_PCT_FULL) - 64'(cur_thr)));
      end
      expected_results = {expected_results, r};
    end
    flows_held = 0;
    bytes_held = '0;
    drop_seen  = 1'b0;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) load_flow(in_data);
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pend_flows.size() > 0) begin
          in_data <= pend_flows.pop_front();
          start   <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else if (!steady_feed) begin
            burst_left = $urandom_range(0, 11);
            gap_left   = $urandom_range(1, 7);
          end
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result for flow %0d", out_data.result_ident));
      end else begin
        seen_result = expected_results.pop_front();
        if (out_data.result_ident !== seen_result.result_ident)
          report_mismatch($sformatf("result_ident %0d, want %0d",
                                    out_data.result_ident, seen_result.result_ident));
        if (out_data.is_large !== seen_result.is_large)
          report_mismatch($sformatf("flow %0d is_large %b, want %b", seen_result.result_ident,
                                    out_data.is_large, seen_result.is_large));
        if (out_data.threshold_error !== seen_result.threshold_error)
          report_mismatch($sformatf("flow %0d threshold_error %b, want %b",
                                    seen_result.result_ident, out_data.threshold_error,
                                    seen_result.threshold_error));
        if (out_data.overflow_flag !== seen_result.overflow_flag)
          report_mismatch($sformatf("flow %0d overflow_flag %b, want %b",
                                    seen_result.result_ident, out_data.overflow_flag,
                                    seen_result.overflow_flag));
        if (out_data.last_result !== seen_result.last_result)
          report_mismatch($sformatf("flow %0d last_result %b, want %b",
                                    seen_result.result_ident, out_data.last_result,
                                    seen_result.last_result));
      end
    end
  end

  task automatic set_config(input logic [LFC_MODE_W-1:0] mode,
                            input logic [LFC_THR_W-1:0] thr);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CLASS_MODE;
    cfg_wdata <= LFC_CFG_DATA_W'(mode);
    @(posedge clk);
    cfg_index <= REG_CLASS_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_mode = mode;
    cur_thr  = thr;
  endtask

  task automatic add_flow(input logic [LFC_BYTES_W-1:0] bytes,
                          input logic [LFC_IDENT_W-1:0] ident, input bit last);
    lfc_in_t f;
    f.flow_bytes = bytes;
    f.flow_ident = ident;
    f.last_flow  = last;
    pend_flows = {pend_flows, f};
    item_total++;
  endtask

  function automatic logic [LFC_BYTES_W-1:0] rand_bytes();
    case ($urandom_range(0, 4))
      0: return LFC_BYTES_W'($urandom_range(0, 15));
      1: return {8'($urandom_range(0, 255)), 32'($urandom)};
      2: return ($urandom_range(0, 1) == 1) ? BYTES_MAX : '0;
      default: return LFC_BYTES_W'($urandom_range(0, 1 << 20));
    endcase
  endfunction

  function automatic logic [LFC_IDENT_W-1:0] rand_ident();
    case ($urandom_range(0, 3))
      0: return LFC_IDENT_W'($urandom_range(0, 3));
      1: return IDENT_MAX;
      default: return LFC_IDENT_W'($urandom);
    endcase
  endfunction

  task automatic add_job(input int n);
    int k;
    for (k = 0; k < n; k++) add_flow(rand_bytes(), rand_ident(), k == n - 1);
  endtask

  // Holds off the next configuration until every transfer is done and the block is idle.
  task automatic drain();
    do @(negedge clk);
    while (pend_flows.size() != 0 || start || expected_results.size() != 0);
    repeat (8) @(negedge clk);
    while (busy) @(negedge clk);
  endtask

  initial begin
    logic [LFC_MODE_W-1:0] mode;
    logic [LFC_THR_W-1:0]  thr;
    int                    phase_no;
    int                    jobs;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_config(MODE_VALUE, THR_MAX);
    add_flow(BYTES_MAX, '0, 1'b0);
    add_flow('0, IDENT_MAX, 1'b0);
    add_flow(BYTES_MAX - 1, 5, 1'b1);
    drain();
    set_config(MODE_UNUSED, 1);
    add_flow(0, 1, 1'b0);
    add_flow(1, 2, 1'b1);
    drain();
    set_config(MODE_COUNT, LFC_THR_W'(LFC_PCT_FULL));
    add_flow(7, 3, 1'b0);
    add_flow(7, 3, 1'b0);
    add_flow(7, 2, 1'b1);
    drain();
    set_config(MODE_COUNT, 1);
    add_flow(9, 4, 1'b0);
    add_flow(9, 4, 1'b1);
    drain();
    set_config(MODE_BYTE_SHARE, 0);
    add_flow(0, 1, 1'b0);
    add_flow(100, 2, 1'b0);
    add_flow(BYTES_MAX, 3, 1'b1);
    drain();
    set_config(MODE_BYTE_SHARE, 5000);
    add_flow(50, 6, 1'b0);
    add_flow(50, 6, 1'b0);
    add_flow(100, 1, 1'b1);
    drain();
    set_config(MODE_BYTE_SHARE, 10001);
    add_flow(1, 1, 1'b0);
    add_flow(2, 2, 1'b1);
    drain();
    set_config(MODE_COUNT, THR_MAX);
    add_flow(BYTES_MAX, IDENT_MAX, 1'b1);
    drain();

    phase_no = 0;
    while (item_total < 370) begin
      mode = LFC_MODE_W'($urandom_range(0, 3));
      if (mode == MODE_VALUE || mode == MODE_UNUSED) begin
        case ($urandom_range(0, 3))
          0: thr = '0;
          1: thr = THR_MAX;
          2: thr = {8'($urandom_range(0, 255)), 32'($urandom)};
          default: thr = LFC_THR_W'($urandom_range(0, 1 << 20));
        endcase
      end else begin
        case ($urandom_range(0, 6))
          0: thr = '0;
          1: thr = LFC_THR_W'(LFC_PCT_FULL);
          2: thr = {8'($urandom_range(0, 255)), 32'($urandom)} | 40'd10001;
          default: thr = LFC_THR_W'($urandom_range(0, 10000));
        endcase
      end
      set_config(mode, thr);
      steady_feed = ($urandom_range(0, 3) == 0);
      jobs = $urandom_range(1, 4);
      repeat (jobs) begin
        add_job(($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8));
      end
      if (phase_no == 2) add_job(LFC_MAX_FLOWS + 2);
      if (phase_no == 6) add_job(LFC_MAX_FLOWS);
      drain();
      phase_no++;
    end

    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatches == 0) begin
      $display("[large_flow_classifier_unit] OK");
    end else begin
      $display("[large_flow_classifier_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #3_200_000;
    $display("[large_flow_classifier_unit] ERROR");
    $finish;
  end

endmodule

/* filelist.f */
src/lfc_pkg.sv
src/large_flow_classifier_unit.sv
src/lfc_checker.sv
tb/large_flow_classifier_unit_tb.sv
